[src/bbr_pkg.sv]
`timescale 1ns / 1ps

package bbr_pkg;

    // Field and datapath widths
    localparam int PIX_W         = 8;
    localparam int CSUM_W        = 10;   // sum of one window column, three pixels
    localparam int SUM_W         = 12;   // sum of nine pixels plus rounding half
    localparam int CNT_W         = 4;    // neighbor count, 1 to 9
    localparam int RECIP_SHIFT   = 18;
    localparam int RECIP_W       = 19;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int OROW_W        = 12;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(768);

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_pix;

    // One window column: [0] two rows up, [1] one row up, [2] current row
    typedef t_pix [2:0] t_col;

    // Line store word: the two previous rows at one column
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_lpair;

    typedef struct packed {
        logic [CSUM_W-1:0] blue;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] red;
    } t_csum;

    typedef struct packed {
        logic keep_top;
        logic keep_bot;
    } t_rowkeep;

    // Border position of one result
    typedef struct packed {
        logic top_ex;
        logic bot_ex;
        logic left_ex;
        logic right_ex;
        logic last;
    } t_flags;

    // Scaled reciprocal, ceil(2^RECIP_SHIFT / n), exact for every window sum
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            CNT_W'(1): m = RECIP_W'(262144);
            CNT_W'(2): m = RECIP_W'(131072);
            CNT_W'(3): m = RECIP_W'(87382);
            CNT_W'(4): m = RECIP_W'(65536);
            CNT_W'(6): m = RECIP_W'(43691);
            CNT_W'(9): m = RECIP_W'(29128);
            default:   m = RECIP_W'(262144);
        endcase
        return m;
    endfunction

endpackage

[src/bbr_if.sv]
`timescale 1ns / 1ps

// Pixel input channel
interface bbr_in_if import bbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

// Result output channel
interface bbr_out_if import bbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// Register write channel
interface bbr_cfg_if import bbr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/bbr_line_store.sv]
`timescale 1ns / 1ps

module bbr_line_store import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_pix              i_wr_pix,
    output t_lpair            o_pair
);

    t_lpair r_mem [MAX_WIDTH];
    t_lpair r_q;
    t_lpair r_byp_word;
    logic   r_byp;
    t_lpair wr_word;

    // Rows move up one line: old middle becomes upper, new pixel becomes middle
    assign wr_word = '{upper: o_pair.middle, middle: i_wr_pix};

    // Write the retiring item, read for the item being accepted
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= wr_word;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_word <= wr_word;
        end
    end

    assign o_pair = r_byp ? r_byp_word : r_q;

endmodule

[src/bbr_cell.sv]
`timescale 1ns / 1ps

module bbr_cell import bbr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_shift,
    input  t_col     i_col,
    input  t_rowkeep i_keep,
    output t_col     o_col,
    output t_csum    o_sum
);

    t_col r_col;

    // Take the neighbor's column on every item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // Column sum over the rows inside the frame
    always_comb begin
        o_sum.red   = (i_keep.keep_top ? CSUM_W'(r_col[0].red) : '0)
                    + CSUM_W'(r_col[1].red)
                    + (i_keep.keep_bot ? CSUM_W'(r_col[2].red) : '0);
        o_sum.green = (i_keep.keep_top ? CSUM_W'(r_col[0].green) : '0)
                    + CSUM_W'(r_col[1].green)
                    + (i_keep.keep_bot ? CSUM_W'(r_col[2].green) : '0);
        o_sum.blue  = (i_keep.keep_top ? CSUM_W'(r_col[0].blue) : '0)
                    + CSUM_W'(r_col[1].blue)
                    + (i_keep.keep_bot ? CSUM_W'(r_col[2].blue) : '0);
    end

endmodule

[src/bbr_mean.sv]
`timescale 1ns / 1ps

module bbr_mean import bbr_pkg::*; (
    input  logic [SUM_W-1:0]   i_sum,
    input  logic [RECIP_W-1:0] i_recip,
    output logic [PIX_W-1:0]   o_mean
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;

    // Divide by the neighbor count through its scaled reciprocal
    assign prod   = PROD_W'(i_sum) * PROD_W'(i_recip);
    assign o_mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

[src/box_blur_3x3_rgb.sv]
`timescale 1ns / 1ps

// 3x3 box blur over a raster stream of RGB pixels. Unless the output stalls, the block
// takes one item per clock and gives one result per clock in steady state: each item
// does one read and one write of the two-row line store (one word per column) and
// shifts the three-cell window once. Item k + frame_width + 1 releases the result for
// pixel k, which passes the stage 1, window, stage 3 and output registers, so after the
// frame's last pixel feed frame_width + 1 drain items (mode 1) to push out the rest;
// the last result of a frame carries frame_last. Each output is the per-channel mean
// over the in-frame neighbors (4 at a corner, 6 on an edge, 9 inside), rounded half up.
// The line store needs no clearing pass: its contents before being written never reach
// a result. Write the frame size registers only while no results are pending.
module box_blur_3x3_rgb import bbr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbr_cfg_if.sink   i_cfg,
    bbr_in_if.sink    i_pix,
    bbr_out_if.source o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > FW_W) ? WW : FW_W;
    localparam logic [1:0] IN_ROW_CAP = 2'd2;
    localparam logic [1:0] ROWS_ALL   = 2'd3;

    // Configuration
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    // Stream positions
    logic [CW-1:0]     r_in_col,  n_in_col;
    logic [1:0]        r_in_row,  n_in_row;
    logic [CW-1:0]     r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    logic [EW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic            in_col_end, out_col_end, out_row_end, emit;
    t_flags          flg;
    t_pix            in_pix;

    // Pipeline
    logic          r_s1_vld, r_s1_emit;
    t_flags        r_s1_flg;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_addr;
    logic          r_w_vld;
    t_flags        r_w_flg;
    logic          r_s3_vld, r_s3_last;
    logic [SUM_W-1:0]   r_s3_red, r_s3_green, r_s3_blue;
    logic [RECIP_W-1:0] r_s3_recip;
    logic          r_o_vld, r_o_last;
    logic [PIX_W-1:0] r_o_red, r_o_green, r_o_blue;

    logic in_acc, out_free, s3_free, s3_go, w_free, w_go, s1_free, s1_go;

    t_lpair   pair;
    t_col     new_col, col2, col1, col0;
    t_csum    sum2, sum1, sum0;
    t_rowkeep keep;
    logic [1:0]       rows, cols;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] tot_red, tot_green, tot_blue, half;
    logic [PIX_W-1:0] mean_red, mean_green, mean_blue;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg.data[FW_W-1:0];
            end
            if (i_cfg.index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg.data[FH_W-1:0];
            end
        end
    end

    // Clamp frame size to the supported range
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = EW'(1);
        end else if (EW'(r_frame_width) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = FH_W'(1);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            eff_h = FH_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // Handshake chain: each stage moves when the one after it has room
    assign out_free = !r_o_vld || o_res.ready;
    assign s3_go    = r_s3_vld && out_free;
    assign s3_free  = !r_s3_vld || out_free;
    assign w_go     = r_w_vld && s3_free;
    assign w_free   = !r_w_vld || s3_free;
    assign s1_go    = r_s1_vld && w_free;
    assign s1_free  = !r_s1_vld || w_free;

    assign i_pix.ready = s1_free;
    assign in_acc      = i_pix.valid && s1_free;

    // Position of this item and of the result it releases
    assign in_col_end  = ((EW+1)'(r_in_col) + (EW+1)'(1)) >= (EW+1)'(eff_w);
    assign out_col_end = ((EW+1)'(r_out_col) + (EW+1)'(1)) >= (EW+1)'(eff_w);
    assign out_row_end = ((FH_W)'(r_out_row) + FH_W'(1)) >= eff_h;
    assign emit        = (r_in_row == IN_ROW_CAP) || ((r_in_row == 2'd1) && (r_in_col != '0));

    assign flg.top_ex   = (r_out_row == '0);
    assign flg.bot_ex   = out_row_end;
    assign flg.left_ex  = (r_out_col == '0);
    assign flg.right_ex = out_col_end;
    assign flg.last     = out_row_end && out_col_end;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_acc) begin
            if (in_col_end) begin
                n_in_col = '0;
                if (r_in_row != IN_ROW_CAP) begin
                    n_in_row = r_in_row + 2'd1;
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (flg.last) begin
                    n_out_col = '0;
                    n_out_row = '0;
                    n_in_col  = '0;
                    n_in_row  = '0;
                end else if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OROW_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Drain items enter as black pixels
    assign in_pix = (i_pix.mode == MODE_DRAIN) ? '0 :
                    t_pix'{blue: i_pix.blue_in, green: i_pix.green_in, red: i_pix.red_in};

    // Stage 1: hold the item while its line store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= in_pix;
            r_s1_addr <= r_in_col;
            r_s1_emit <= emit;
            r_s1_flg  <= flg;
        end
    end

    bbr_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_col),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_pix  (r_s1_pix),
        .o_pair    (pair)
    );

    // Window: three cells, new column enters on the right
    assign new_col[0] = pair.upper;
    assign new_col[1] = pair.middle;
    assign new_col[2] = r_s1_pix;

    assign keep.keep_top = !r_w_flg.top_ex;
    assign keep.keep_bot = !r_w_flg.bot_ex;

    bbr_cell u_cell2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_col   (new_col),
        .i_keep  (keep),
        .o_col   (col2),
        .o_sum   (sum2)
    );

    bbr_cell u_cell1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_col   (col2),
        .i_keep  (keep),
        .o_col   (col1),
        .o_sum   (sum1)
    );

    bbr_cell u_cell0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_col   (col1),
        .i_keep  (keep),
        .o_col   (col0),
        .o_sum   (sum0)
    );

    // Window stage: valid only for items that release a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if (s1_go) begin
            r_w_vld <= r_s1_emit;
        end else if (w_go) begin
            r_w_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_w_flg <= r_s1_flg;
        end
    end

    // Add the in-frame columns, count neighbors, add the rounding half
    assign rows = ROWS_ALL - {1'b0, r_w_flg.top_ex} - {1'b0, r_w_flg.bot_ex};
    assign cols = ROWS_ALL - {1'b0, r_w_flg.left_ex} - {1'b0, r_w_flg.right_ex};
    assign cnt  = CNT_W'(rows) * CNT_W'(cols);
    assign half = SUM_W'(cnt >> 1);

    assign tot_red   = (r_w_flg.left_ex ? '0 : SUM_W'(sum0.red)) + SUM_W'(sum1.red)
                     + (r_w_flg.right_ex ? '0 : SUM_W'(sum2.red));
    assign tot_green = (r_w_flg.left_ex ? '0 : SUM_W'(sum0.green)) + SUM_W'(sum1.green)
                     + (r_w_flg.right_ex ? '0 : SUM_W'(sum2.green));
    assign tot_blue  = (r_w_flg.left_ex ? '0 : SUM_W'(sum0.blue)) + SUM_W'(sum1.blue)
                     + (r_w_flg.right_ex ? '0 : SUM_W'(sum2.blue));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_go) begin
            r_s3_vld <= 1'b1;
        end else if (s3_go) begin
            r_s3_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_s3_red   <= tot_red + half;
            r_s3_green <= tot_green + half;
            r_s3_blue  <= tot_blue + half;
            r_s3_recip <= recip_of(cnt);
            r_s3_last  <= r_w_flg.last;
        end
    end

    // Divide each channel by the neighbor count
    bbr_mean u_mean_red (
        .i_sum   (r_s3_red),
        .i_recip (r_s3_recip),
        .o_mean  (mean_red)
    );

    bbr_mean u_mean_green (
        .i_sum   (r_s3_green),
        .i_recip (r_s3_recip),
        .o_mean  (mean_green)
    );

    bbr_mean u_mean_blue (
        .i_sum   (r_s3_blue),
        .i_recip (r_s3_recip),
        .o_mean  (mean_blue)
    );

    // Output register: hold the item until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s3_go) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_o_red   <= mean_red;
            r_o_green <= mean_green;
            r_o_blue  <= mean_blue;
            r_o_last  <= r_s3_last;
        end
    end

    assign o_res.valid      = r_o_vld;
    assign o_res.red_out    = r_o_red;
    assign o_res.green_out  = r_o_green;
    assign o_res.blue_out   = r_o_blue;
    assign o_res.frame_last = r_o_last;

endmodule

[src/bbr_checker.sv]
`timescale 1ns / 1ps

module bbr_checker import bbr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [3*PIX_W:0] i_out_data
);

    logic [31:0] r_pend;
    logic        in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track items taken in but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 32'(in_acc) - 32'(out_acc);
        end
    end

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // With the output free the whole pipeline has room
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled with the output free");

    // Every result answers an item taken earlier
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pend != '0))
        else $error("result without a pending item");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.frame_last, o_res.blue_out, o_res.green_out, o_res.red_out})
);
